>>> sv/frqih_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Frame-rotated query ID hash: shared package
// Payload types, command codes, default sizes and the command and status
// bundles that join the controller and the datapath.
// ============================================================================
package frqih_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int CMD_W  = 2;
    localparam int QID_W  = 32;
    localparam int OCID_W = 9;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_NEW_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND      = 2'd2;

    // Default sizes.
    localparam int DEF_FRAMES    = 3;
    localparam int DEF_SLOTS     = 128;
    localparam int DEF_HASH_BITS = 7;

    // Input transaction.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [QID_W-1:0] query_id;
    } t_in_item;

    // Result transaction.
    typedef struct packed {
        logic [OCID_W-1:0] ocid;
        logic              hit;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture the accepted input transaction
        logic new_frame;    // rotate the frames and restart the slot counter
        logic clr;          // write an empty head and step the clear address
        logic head_rd;      // read the bucket head
        logic add_wr;       // link a new entry in at the bucket head
        logic ent_rd_head;  // read the entry that the bucket head names
        logic ent_rd_link;  // read the entry that the current link names
        logic res_zero;     // result: no slot, no hit
        logic res_add;      // result: the slot just allocated
        logic res_find;     // result: the slot just matched
        logic out_load;     // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic head_zero;
        logic link_zero;
        logic match;
        logic clr_last_row;
        logic clr_last_all;
        logic out_free;
    } t_dp_stat;

endpackage

>>> sv/frqih_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Frame-rotated query ID hash: generic RAM
// One write port and one read port with a registered read.
// ============================================================================
module frqih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/frqih_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// Frame-rotated query ID hash: datapath
// Frame pointers, slot counter, bucket head and entry memories, chain
// pointer, result register and output register.
// ============================================================================
module frqih_dp #(
    parameter int FRAMES    = frqih_pkg::DEF_FRAMES,
    parameter int SLOTS     = frqih_pkg::DEF_SLOTS,
    parameter int HASH_BITS = frqih_pkg::DEF_HASH_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  frqih_pkg::t_in_item  i_in_data,
    input  frqih_pkg::t_dp_cmd   i_cmd,
    output frqih_pkg::t_dp_stat  o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output frqih_pkg::t_out_item o_out_data
);
    import frqih_pkg::*;

    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int HEAD_DEPTH = FRAMES << HASH_BITS;
    localparam int ENT_DEPTH  = FRAMES << SLOT_W;
    localparam int HA_W       = $clog2(HEAD_DEPTH);
    localparam int EA_W       = $clog2(ENT_DEPTH);
    localparam int ENT_W      = QID_W + SLOT_W;

    // Captured transaction.
    logic [CMD_W-1:0]   r_cmd;
    logic [QID_W-1:0]   r_qid;
    logic [HASH_BITS-1:0] bucket;

    // Frame pointers and the insert frame's slot counter.
    logic [FRAME_W-1:0] r_ins;
    logic [FRAME_W-1:0] r_lk;
    logic [FRAME_W-1:0] n_ins;
    logic [CNT_W-1:0]   r_next_slot;

    // Clear sweep address, chain pointer, result and output registers.
    logic [HA_W-1:0]    r_clr_addr;
    logic [SLOT_W-1:0]  r_cur;
    logic [SLOT_W-1:0]  cur_sel;
    t_out_item          r_res;
    t_out_item          r_out;
    logic               r_out_valid;

    // Memory ports.
    logic               h_we;
    logic [HA_W-1:0]    h_waddr;
    logic [SLOT_W-1:0]  h_wdata;
    logic [HA_W-1:0]    h_raddr;
    logic [SLOT_W-1:0]  h_rdata;
    logic               e_re;
    logic [EA_W-1:0]    e_waddr;
    logic [ENT_W-1:0]   e_wdata;
    logic [EA_W-1:0]    e_raddr;
    logic [ENT_W-1:0]   e_rdata;
    logic [SLOT_W-1:0]  e_link;
    logic [QID_W-1:0]   e_query;

    // Result slot numbers with the frame offset, cut to the output width.
    logic [31:0]        ocid_add_full;
    logic [31:0]        ocid_find_full;

    assign bucket  = r_qid[HASH_BITS-1:0];
    assign e_link  = e_rdata[SLOT_W-1:0];
    assign e_query = e_rdata[ENT_W-1:SLOT_W];
    assign n_ins   = (r_ins == FRAME_W'(FRAMES - 1)) ? '0 : r_ins + FRAME_W'(1);

    // Transaction capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_data.cmd;
            r_qid <= i_in_data.query_id;
        end
    end

    // Frame rotation, slot allocation and the clear sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins       <= FRAME_W'(1 % FRAMES);
            r_lk        <= '0;
            r_next_slot <= CNT_W'(1);
            r_clr_addr  <= '0;
        end else begin
            if (i_cmd.new_frame) begin
                r_lk        <= r_ins;
                r_ins       <= n_ins;
                r_next_slot <= CNT_W'(1);
                r_clr_addr  <= {n_ins, {HASH_BITS{1'b0}}};
            end else if (i_cmd.add_wr) begin
                r_next_slot <= r_next_slot + CNT_W'(1);
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + HA_W'(1);
            end
        end
    end

    // Bucket head memory: cleared by sweep, written on an add.
    always_comb begin
        h_we    = i_cmd.clr | i_cmd.add_wr;
        h_waddr = i_cmd.clr ? r_clr_addr : {r_ins, bucket};
        h_wdata = i_cmd.clr ? '0 : r_next_slot[SLOT_W-1:0];
        h_raddr = {(r_cmd == CMD_ADD) ? r_ins : r_lk, bucket};
    end

    frqih_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (HEAD_DEPTH)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (i_cmd.head_rd),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    // Entry memory: query ID and link per slot. The chain walk reads either
    // the head entry or the link of the entry just read.
    always_comb begin
        e_waddr = {r_ins, r_next_slot[SLOT_W-1:0]};
        e_wdata = {r_qid, h_rdata};
        cur_sel = i_cmd.ent_rd_head ? h_rdata : e_link;
        e_raddr = {r_lk, cur_sel};
        e_re    = i_cmd.ent_rd_head | i_cmd.ent_rd_link;
    end

    frqih_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENT_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_wr),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    // The chain pointer tracks the entry whose data the memory returns next.
    always_ff @(posedge i_clk) begin
        if (e_re) begin
            r_cur <= cur_sel;
        end
    end

    // Result selection.
    assign ocid_add_full  = 32'(r_ins) * 32'(SLOTS) + 32'(r_next_slot);
    assign ocid_find_full = 32'(r_lk) * 32'(SLOTS) + 32'(r_cur);

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_res <= '0;
        end else if (i_cmd.res_add) begin
            r_res.ocid <= ocid_add_full[OCID_W-1:0];
            r_res.hit  <= 1'b1;
        end else if (i_cmd.res_find) begin
            r_res.ocid <= ocid_find_full[OCID_W-1:0];
            r_res.hit  <= 1'b1;
        end
    end

    // Output register; it frees up in the cycle its transaction is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status for the controller.
    always_comb begin
        o_stat.full         = r_next_slot >= CNT_W'(SLOTS);
        o_stat.head_zero    = h_rdata == '0;
        o_stat.link_zero    = e_link == '0;
        o_stat.match        = e_query == r_qid;
        o_stat.clr_last_row = &r_clr_addr[HASH_BITS-1:0];
        o_stat.clr_last_all = r_clr_addr == HA_W'(HEAD_DEPTH - 1);
        o_stat.out_free     = !r_out_valid || i_out_ready;
    end

endmodule

>>> sv/frqih_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// Frame-rotated query ID hash: controller
// State machine that sequences the clear sweeps, the add, the chain walk of
// a find and the hand-off of each result to the output register.
// ============================================================================
module frqih_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [frqih_pkg::CMD_W-1:0] i_in_cmd,
    input  frqih_pkg::t_dp_stat         i_stat,
    output frqih_pkg::t_dp_cmd          o_cmd
);
    import frqih_pkg::*;

    localparam logic [3:0] ST_RST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_NF        = 4'd2;
    localparam logic [3:0] ST_NF_CLR    = 4'd3;
    localparam logic [3:0] ST_ADD_RD    = 4'd4;
    localparam logic [3:0] ST_ADD_WR    = 4'd5;
    localparam logic [3:0] ST_FIND_RD   = 4'd6;
    localparam logic [3:0] ST_FIND_HEAD = 4'd7;
    localparam logic [3:0] ST_FIND_CHK  = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // State register; reset starts the sweep that empties every bucket.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_RST_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last_all) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_in_cmd)
                        CMD_NEW_FRAME: n_state = ST_NF;
                        CMD_ADD:       n_state = ST_ADD_RD;
                        CMD_FIND:      n_state = ST_FIND_RD;
                        default: begin
                            o_cmd.res_zero = 1'b1;
                            n_state        = ST_DONE;
                        end
                    endcase
                end
            end
            ST_NF: begin
                o_cmd.new_frame = 1'b1;
                n_state         = ST_NF_CLR;
            end
            ST_NF_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last_row) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = ST_DONE;
                end
            end
            ST_ADD_RD: begin
                if (i_stat.full) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.head_rd = 1'b1;
                    n_state       = ST_ADD_WR;
                end
            end
            ST_ADD_WR: begin
                o_cmd.add_wr  = 1'b1;
                o_cmd.res_add = 1'b1;
                n_state       = ST_DONE;
            end
            ST_FIND_RD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = ST_FIND_HEAD;
            end
            ST_FIND_HEAD: begin
                if (i_stat.head_zero) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.ent_rd_head = 1'b1;
                    n_state           = ST_FIND_CHK;
                end
            end
            ST_FIND_CHK: begin
                // One chain entry is compared per cycle.
                if (i_stat.match) begin
                    o_cmd.res_find = 1'b1;
                    n_state        = ST_DONE;
                end else if (i_stat.link_zero) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.ent_rd_link = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/frame_rotated_query_id_hash_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Frame-rotated query ID hash core
// Ring of per-frame chained hash tables mapping query IDs to slot numbers.
// ============================================================================
// The core takes one transaction at a time and returns exactly one result
// transaction for each. An add reads the bucket head, writes the new entry
// and loads its result into the output register, or loads a miss when the
// insert table is already full. A find loads a miss when the bucket is
// empty and otherwise walks the chain from the bucket head; the chain walk
// reads one entry of the entry memory per cycle. A new-frame command sweeps
// the bucket heads of the new insert table through the single head memory
// write port, one bucket per cycle. After reset the core empties all
// FRAMES * BUCKETS bucket heads before it raises o_in_ready. The output
// register lets the next transaction be accepted while a result still waits
// to be taken.
module frame_rotated_query_id_hash_core #(
    parameter int FRAMES    = frqih_pkg::DEF_FRAMES,
    parameter int SLOTS     = frqih_pkg::DEF_SLOTS,
    parameter int HASH_BITS = frqih_pkg::DEF_HASH_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  frqih_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output frqih_pkg::t_out_item o_out_data
);
    import frqih_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Controller.
    frqih_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_cmd   (i_in_data.cmd),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Datapath.
    frqih_dp #(
        .FRAMES    (FRAMES),
        .SLOTS     (SLOTS),
        .HASH_BITS (HASH_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // An accepted transaction keeps the input closed in the next cycle.
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input stayed open after an accepted transaction");

    // A miss always reports slot zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |-> (o_out_data.ocid == '0))
        else $error("result without hit carries a nonzero slot");

    // A new result is never loaded in the cycle that accepts a transaction.
    a_load_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result loaded while the core was idle");

endmodule

>>> tb/tb_frame_rotated_query_id_hash_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Frame-rotated query ID hash core: self-checking testbench
// Drives new-frame, add, find and unused commands through the input channel.
// A behavioral copy of the frame ring and its chained tables predicts each
// result, and every result transaction is checked against the oldest
// prediction. The run covers directed corner cases, a full table, and random
// frame rounds under several idle and stall patterns.
// ============================================================================
module tb_frame_rotated_query_id_hash_core;
    import frqih_pkg::*;

    localparam int FRAMES    = DEF_FRAMES;
    localparam int SLOTS     = DEF_SLOTS;
    localparam int HASH_BITS = DEF_HASH_BITS;
    localparam int BUCKETS   = 1 << HASH_BITS;
    localparam int SLOT_W    = $clog2(SLOTS) + 1;
    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int CLK_HALF  = 4;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    frame_rotated_query_id_hash_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Shadow copy of the frame ring and the per-frame chained tables.
    logic [FRAME_W-1:0] ins_frame;
    logic [FRAME_W-1:0] look_frame;
    logic [SLOT_W-1:0]  slot_ctr  [FRAMES];
    logic [SLOT_W-1:0]  head_tab  [FRAMES][BUCKETS];
    logic [QID_W-1:0]   qid_tab   [FRAMES][SLOTS];
    logic [SLOT_W-1:0]  link_tab  [FRAMES][SLOTS];

    t_out_item        expected_results[$];
    logic [QID_W-1:0] cur_ids[$];
    logic [QID_W-1:0] prev_ids[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Apply one command to the shadow tables and return the expected result.
    function automatic t_out_item predict_lookup(input t_in_item item);
        t_out_item          res;
        int                 fr;
        int                 bkt;
        int                 slot;
        logic [SLOT_W-1:0]  cur;
        int                 steps;
        res = '0;
        bkt = int'(item.query_id[HASH_BITS-1:0]);
        case (item.cmd)
            CMD_NEW_FRAME: begin
                look_frame = ins_frame;
                ins_frame  = FRAME_W'((int'(ins_frame) + 1) % FRAMES);
                for (int i = 0; i < BUCKETS; i++) begin
                    head_tab[ins_frame][i] = '0;
                end
                slot_ctr[ins_frame] = SLOT_W'(1);
            end
            CMD_ADD: begin
                fr   = int'(ins_frame);
                slot = int'(slot_ctr[fr]);
                if (slot >= 1 && slot < SLOTS) begin
                    qid_tab[fr][slot]  = item.query_id;
                    link_tab[fr][slot] = head_tab[fr][bkt];
                    head_tab[fr][bkt]  = SLOT_W'(slot);
                    slot_ctr[fr]       = SLOT_W'(slot + 1);
                    res.ocid = OCID_W'(slot + fr * SLOTS);
                    res.hit  = 1'b1;
                end
            end
            CMD_FIND: begin
                fr    = int'(look_frame);
                cur   = head_tab[fr][bkt];
                steps = 0;
                // Walk from the head so the latest insert of a duplicate wins.
                while (steps < SLOTS && cur != 0 && int'(cur) < SLOTS && !res.hit) begin
                    if (qid_tab[fr][cur] == item.query_id) begin
                        res.ocid = OCID_W'(int'(cur) + fr * SLOTS);
                        res.hit  = 1'b1;
                    end else begin
                        cur = link_tab[fr][cur];
                    end
                    steps++;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Query IDs that pile up in a few buckets, so that chains grow long.
    function automatic logic [QID_W-1:0] clustered_id();
        logic [QID_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 9) < 6) begin
            v = (v & ~QID_W'(BUCKETS - 1)) | QID_W'($urandom_range(0, 3));
        end
        return v;
    endfunction

    // Send one command transaction and record its expected result.
    task automatic drive_command(input logic [CMD_W-1:0] cmd, input logic [QID_W-1:0] qid);
        t_in_item item;
        item.cmd      = cmd;
        item.query_id = qid;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        expected_results.push_back(predict_lookup(item));
        items_sent++;
    endtask

    // Receiver: random backpressure on the result channel.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: ocid %0d hit %0b", o_out_data.ocid, o_out_data.hit);
                mismatch_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_out_data.ocid !== exp_res.ocid) begin
                    $error("ocid mismatch: expected %0d actual %0d", exp_res.ocid,
                           o_out_data.ocid);
                    mismatch_count++;
                end
                if (o_out_data.hit !== exp_res.hit) begin
                    $error("hit mismatch: expected %0b actual %0b", exp_res.hit,
                           o_out_data.hit);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Corner cases: empty lookup, extreme IDs, collisions, duplicates, unused
    // command and the rotation of the frame ring.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drive_command(CMD_FIND, 32'h0000_0000);
        drive_command(CMD_FIND, 32'hFFFF_FFFF);
        drive_command(CMD_ADD, 32'h0000_0000);
        drive_command(CMD_ADD, 32'hFFFF_FFFF);
        drive_command(CMD_ADD, 32'h0000_0080);
        drive_command(CMD_ADD, 32'h0000_0000);
        drive_command(CMD_UNUSED, 32'h5A5A_5A5A);
        drive_command(CMD_UNUSED, 32'hA5A5_A5A5);
        drive_command(CMD_NEW_FRAME, 32'hFFFF_FFFF);
        drive_command(CMD_FIND, 32'h0000_0000);
        drive_command(CMD_FIND, 32'h0000_0080);
        drive_command(CMD_FIND, 32'hFFFF_FFFF);
        drive_command(CMD_FIND, 32'h0000_0100);
        drive_command(CMD_FIND, 32'h7FFF_FFFF);
        drive_command(CMD_ADD, 32'h1234_5678);
        drive_command(CMD_NEW_FRAME, 32'h0000_0000);
        drive_command(CMD_FIND, 32'h1234_5678);
        drive_command(CMD_NEW_FRAME, 32'h0000_0000);
        drive_command(CMD_FIND, 32'h0000_0000);
        drive_command(CMD_ADD, 32'hFFFF_FFFF);
        drive_command(CMD_NEW_FRAME, 32'h0000_0000);
        drive_command(CMD_FIND, 32'hFFFF_FFFF);
    endtask

    // Fill one insert table to the last slot, then add past the end.
    task automatic test_table_full();
        logic [QID_W-1:0] last_id;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drive_command(CMD_NEW_FRAME, $urandom);
        for (int k = 0; k < SLOTS + 1; k++) begin
            last_id = clustered_id();
            drive_command(CMD_ADD, last_id);
        end
        drive_command(CMD_NEW_FRAME, $urandom);
        drive_command(CMD_FIND, last_id);
        drive_command(CMD_FIND, 32'h0000_0003);
    endtask

    // One frame round: rotate, then mix adds into the new table with finds
    // against the frame that was just closed, plus some noise.
    task automatic run_frame_round();
        int               n_ops;
        int               roll;
        bit               fill;
        logic [QID_W-1:0] qid;
        logic [CMD_W-1:0] cmd;
        drive_command(CMD_NEW_FRAME, $urandom);
        prev_ids = cur_ids;
        cur_ids.delete();
        fill  = ($urandom_range(0, 7) == 0);
        n_ops = fill ? $urandom_range(SLOTS, SLOTS + 12) : $urandom_range(4, 40);
        for (int k = 0; k < n_ops; k++) begin
            roll = $urandom_range(0, 99);
            if (fill || roll < 45) begin
                if (cur_ids.size() > 0 && $urandom_range(0, 4) == 0) begin
                    qid = cur_ids[$urandom_range(0, cur_ids.size() - 1)];
                end else begin
                    qid = clustered_id();
                end
                cur_ids.push_back(qid);
                drive_command(CMD_ADD, qid);
            end else if (roll < 90) begin
                if (prev_ids.size() > 0 && $urandom_range(0, 9) < 7) begin
                    qid = prev_ids[$urandom_range(0, prev_ids.size() - 1)];
                end else begin
                    qid = clustered_id();
                end
                drive_command(CMD_FIND, qid);
            end else begin
                cmd = CMD_W'($urandom_range(0, 3));
                drive_command(cmd, $urandom);
                if (cmd == CMD_NEW_FRAME) begin
                    prev_ids = cur_ids;
                    cur_ids.delete();
                end
            end
        end
    endtask

    // Random frame rounds under one idle and stall pattern.
    task automatic test_random_rounds(input int idle_pct, input int stall_pct,
                                      input int n_items);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            run_frame_round();
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        ins_frame   = FRAME_W'(1 % FRAMES);
        look_frame  = '0;
        for (int f = 0; f < FRAMES; f++) begin
            slot_ctr[f] = SLOT_W'(1);
            for (int b = 0; b < BUCKETS; b++) begin
                head_tab[f][b] = '0;
            end
            for (int s = 0; s < SLOTS; s++) begin
                qid_tab[f][s]  = '0;
                link_tab[f][s] = '0;
            end
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_table_full();
        test_random_rounds(0, 0, 260);
        test_random_rounds(76, 0, 260);
        test_random_rounds(0, 76, 260);
        test_random_rounds(31, 31, 260);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
